### design/hvd_pkg.sv
package hvd_pkg;

    // Angles and fixed-point scales
    localparam logic [33:0] PI_Q32     = 34'h3243F6A88;
    localparam logic [16:0] PI_HI      = PI_Q32[33:17];
    localparam logic [16:0] PI_LO      = PI_Q32[16:0];
    localparam logic [30:0] HALF_PI    = PI_Q32[33:3];
    localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
    localparam logic [60:0] ONE_Q60    = 61'h1000_0000_0000_0000;

    // Coordinate limits, degrees * 2^20
    localparam logic signed [27:0] LAT_LIMIT  = 28'sd94371840;
    localparam logic signed [28:0] LON_LIMIT  = 29'sd188743680;
    localparam logic [28:0]        DEG90_Q21  = 29'd188743680;
    localparam logic [28:0]        DEG180_Q21 = 29'd377487360;

    // 2 * 6371 km * 256
    localparam logic [21:0] DIST_SCALE = 22'd3261952;
    localparam logic [53:0] DIST_ROUND = 54'd536870912;
    localparam logic [22:0] DIST_MAX   = 23'd5124000;

    // Divisor used to turn degrees into radians (180 = 4 * 45)
    localparam int DEG_DIV = 45;

    // Pipeline depths
    localparam int SIN_TERMS     = 8;
    localparam int SIN_CELL_LAT  = 4;
    localparam int SIN_LAT       = 10 + SIN_TERMS * SIN_CELL_LAT;
    localparam int SQRT_STEPS    = 31;
    localparam int ASIN_TERMS    = 28;
    localparam int ASIN_CELL_LAT = 7;
    localparam int ASIN_LAT      = ASIN_TERMS * ASIN_CELL_LAT;
    localparam int TOTAL_LAT     = 3 + SIN_LAT + 3 + SQRT_STEPS + 2 + ASIN_LAT + 3;

endpackage

### design/hvd_cdiv.sv
module hvd_cdiv #(
    parameter int W = 32,
    parameter int D = 3
) (
    input  logic         i_clk,
    input  logic [W-1:0] i_x,
    output logic [W-1:0] o_q,
    output logic [W-1:0] o_rem
);

    localparam int          W2    = 2 * W;
    localparam logic [63:0] MFULL = (64'd1 << W) / D;
    localparam logic [W-1:0] M    = MFULL[W-1:0];

    logic [W-1:0]  r_x;
    logic [W2-1:0] r_p;
    logic [W-1:0]  w_qe;
    logic [W-1:0]  w_qd;
    logic [W-1:0]  w_rem;
    logic [W-1:0]  n_q;
    logic [W-1:0]  n_rem;
    logic [W-1:0]  r_q;
    logic [W-1:0]  r_rem;

    // estimate is the true quotient or one below it
    always_ff @(posedge i_clk) begin
        r_x <= i_x;
        r_p <= W2'(i_x) * W2'(M);
    end

    always_comb begin
        w_qe  = r_p[W2-1:W];
        w_qd  = W'(W2'(w_qe) * W2'(D));
        w_rem = r_x - w_qd;
        if (w_rem >= W'(D)) begin
            n_q   = w_qe + W'(1);
            n_rem = w_rem - W'(D);
        end else begin
            n_q   = w_qe;
            n_rem = w_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q   <= n_q;
        r_rem <= n_rem;
    end

    assign o_q   = r_q;
    assign o_rem = r_rem;

endmodule

### design/hvd_sin_cell.sv
module hvd_sin_cell #(
    parameter int K = 0
) (
    input  logic               i_clk,
    input  logic [30:0]        i_t,
    input  logic [31:0]        i_r2,
    input  logic signed [32:0] i_s,
    output logic [30:0]        o_t,
    output logic [31:0]        o_r2,
    output logic signed [32:0] o_s
);

    localparam int D = (2 * K + 2) * (2 * K + 3);

    logic [31:0]        r_m;
    logic [31:0]        r_r2_1, r_r2_2, r_r2_3, r_r2_4;
    logic signed [32:0] r_s_1, r_s_2, r_s_3, r_s_4;
    logic [30:0]        r_t;
    logic [31:0]        w_q;
    logic [62:0]        w_prod;
    logic signed [32:0] w_qs;

    assign w_prod = 63'(i_t) * 63'(i_r2);

    always_ff @(posedge i_clk) begin
        r_m    <= w_prod[61:30];
        r_r2_1 <= i_r2;
        r_s_1  <= i_s;
    end

    hvd_cdiv #(.W(32), .D(D)) u_div (
        .i_clk (i_clk),
        .i_x   (r_m),
        .o_q   (w_q),
        .o_rem ()
    );

    assign w_qs = $signed({1'b0, w_q});

    // alternate signs of the series
    always_ff @(posedge i_clk) begin
        r_r2_2 <= r_r2_1;
        r_r2_3 <= r_r2_2;
        r_s_2  <= r_s_1;
        r_s_3  <= r_s_2;
        r_t    <= w_q[30:0];
        r_r2_4 <= r_r2_3;
        if ((K % 2) == 0) begin
            r_s_4 <= r_s_3 - w_qs;
        end else begin
            r_s_4 <= r_s_3 + w_qs;
        end
    end

    assign o_t  = r_t;
    assign o_r2 = r_r2_4;
    assign o_s  = r_s_4;

endmodule

### design/hvd_sin.sv
module hvd_sin (
    input  logic        i_clk,
    input  logic [28:0] i_u,
    output logic [30:0] o_sin
);

    logic [28:0]        w_uc;
    logic [27:0]        r_uf;
    logic [44:0]        r_phi, r_plo;
    logic [61:0]        w_sum;
    logic [36:0]        r_x;
    logic [19:0]        r_xl1, r_xl2;
    logic [16:0]        w_qa, w_ra;
    logic [16:0]        r_qh1, r_qh2;
    logic [25:0]        w_qb;
    logic [30:0]        r_r;
    logic [61:0]        w_sq;
    logic [30:0]        w_t [0:hvd_pkg::SIN_TERMS];
    logic [31:0]        w_r2 [0:hvd_pkg::SIN_TERMS];
    logic signed [32:0] w_s [0:hvd_pkg::SIN_TERMS];
    logic [30:0]        r_t0;
    logic [31:0]        r_r20;
    logic signed [32:0] r_s0;
    logic [30:0]        r_sin;
    logic signed [32:0] w_last;

    // fold into the first quadrant
    always_comb begin
        w_uc = (i_u > hvd_pkg::DEG180_Q21) ? hvd_pkg::DEG180_Q21 : i_u;
        if (w_uc > hvd_pkg::DEG90_Q21) begin
            w_uc = hvd_pkg::DEG180_Q21 - w_uc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_uf  <= w_uc[27:0];
        r_phi <= 45'(r_uf) * 45'(hvd_pkg::PI_HI);
        r_plo <= 45'(r_uf) * 45'(hvd_pkg::PI_LO);
        r_x   <= w_sum[61:25];
    end

    assign w_sum = (62'(r_phi) << 17) + 62'(r_plo);

    // divide by 45 in two pieces: high bits, then remainder with low bits
    hvd_cdiv #(.W(17), .D(hvd_pkg::DEG_DIV)) u_div_hi (
        .i_clk (i_clk),
        .i_x   (r_x[36:20]),
        .o_q   (w_qa),
        .o_rem (w_ra)
    );

    hvd_cdiv #(.W(26), .D(hvd_pkg::DEG_DIV)) u_div_lo (
        .i_clk (i_clk),
        .i_x   ({w_ra[5:0], r_xl2}),
        .o_q   (w_qb),
        .o_rem ()
    );

    assign w_sq = 62'(r_r) * 62'(r_r);

    always_ff @(posedge i_clk) begin
        r_xl1 <= r_x[19:0];
        r_xl2 <= r_xl1;
        r_qh1 <= w_qa;
        r_qh2 <= r_qh1;
        r_r   <= {r_qh2[10:0], w_qb[19:0]};
        r_t0  <= r_r;
        r_r20 <= w_sq[61:30];
        r_s0  <= $signed({2'b00, r_r});
    end

    assign w_t[0]  = r_t0;
    assign w_r2[0] = r_r20;
    assign w_s[0]  = r_s0;

    for (genvar k = 0; k < hvd_pkg::SIN_TERMS; k++) begin : g_term
        hvd_sin_cell #(.K(k)) u_cell (
            .i_clk (i_clk),
            .i_t   (w_t[k]),
            .i_r2  (w_r2[k]),
            .i_s   (w_s[k]),
            .o_t   (w_t[k+1]),
            .o_r2  (w_r2[k+1]),
            .o_s   (w_s[k+1])
        );
    end

    assign w_last = w_s[hvd_pkg::SIN_TERMS];

    always_ff @(posedge i_clk) begin
        if (w_last < 0) begin
            r_sin <= '0;
        end else if (w_last > $signed({2'b00, hvd_pkg::ONE_Q30})) begin
            r_sin <= hvd_pkg::ONE_Q30;
        end else begin
            r_sin <= w_last[30:0];
        end
    end

    assign o_sin = r_sin;

endmodule

### design/hvd_sqrt_cell.sv
module hvd_sqrt_cell #(
    parameter int I = 0
) (
    input  logic        i_clk,
    input  logic [60:0] i_n,
    input  logic [61:0] i_res,
    output logic [60:0] o_n,
    output logic [61:0] o_res
);

    localparam logic [61:0] BIT = 62'(1) << (2 * I);

    logic [61:0] w_trial;
    logic [61:0] w_diff;
    logic [60:0] r_n;
    logic [61:0] r_res;

    assign w_trial = i_res + BIT;
    assign w_diff  = 62'(i_n) - w_trial;

    // one root bit per step
    always_ff @(posedge i_clk) begin
        if (62'(i_n) >= w_trial) begin
            r_n   <= w_diff[60:0];
            r_res <= (i_res >> 1) + BIT;
        end else begin
            r_n   <= i_n;
            r_res <= i_res >> 1;
        end
    end

    assign o_n   = r_n;
    assign o_res = r_res;

endmodule

### design/hvd_asin_cell.sv
module hvd_asin_cell #(
    parameter int N = 0
) (
    input  logic        i_clk,
    input  logic [30:0] i_t,
    input  logic [30:0] i_z2,
    input  logic [31:0] i_sum,
    output logic [30:0] o_t,
    output logic [30:0] o_z2,
    output logic [31:0] o_sum
);

    localparam int DA = 2 * N + 2;
    localparam int DB = 2 * N + 3;

    logic [61:0] w_prod;
    logic [30:0] r_m1, r_m2, r_m3;
    logic [31:0] r_mc;
    logic [31:0] w_qa;
    logic [30:0] r_t4, r_t5, r_t6, r_t7;
    logic [30:0] w_qb;
    logic [30:0] r_z2 [0:6];
    logic [31:0] r_sum [0:6];

    assign w_prod = 62'(i_t) * 62'(i_z2);

    // t * (DA-1) / DA taken as t - ceil(t / DA)
    always_ff @(posedge i_clk) begin
        r_m1 <= w_prod[60:30];
        r_mc <= 32'(w_prod[60:30]) + 32'(DA - 1);
        r_m2 <= r_m1;
        r_m3 <= r_m2;
        r_t4 <= r_m3 - w_qa[30:0];
        r_t5 <= r_t4;
        r_t6 <= r_t5;
        r_t7 <= r_t6;
    end

    hvd_cdiv #(.W(32), .D(DA)) u_div_a (
        .i_clk (i_clk),
        .i_x   (r_mc),
        .o_q   (w_qa),
        .o_rem ()
    );

    hvd_cdiv #(.W(31), .D(DB)) u_div_b (
        .i_clk (i_clk),
        .i_x   (r_t4),
        .o_q   (w_qb),
        .o_rem ()
    );

    always_ff @(posedge i_clk) begin
        r_z2[0]  <= i_z2;
        r_sum[0] <= i_sum;
        for (int j = 1; j < 6; j++) begin
            r_z2[j]  <= r_z2[j-1];
            r_sum[j] <= r_sum[j-1];
        end
        r_z2[6]  <= r_z2[5];
        r_sum[6] <= r_sum[5] + 32'(w_qb);
    end

    assign o_t   = r_t7;
    assign o_z2  = r_z2[6];
    assign o_sum = r_sum[6];

endmodule

### design/haversine_distance_top.sv
// Great-circle distance between two points (haversine), fully pipelined.
//
// Input channel: the four coordinates (degrees * 2^20, two's complement)
// are taken as one beat at a rising edge where start is high and busy is
// low. busy stays low once it drops after reset, so a new beat can enter in
// every cycle: throughput is one beat per clock.
//
// Result channel: o_distance_km (km * 256) is shown for exactly one cycle
// with o_done high, when the beat's valid bit leaves the r_vld shift line.
// The path runs through four parallel sine units (eight series cells
// each), the products forming a, two 31-step square-root cell chains,
// and 28 arcsine series cells.
// Results leave in input order; the receiver cannot stall the block.
//
// Reset (i_rst_n low, synchronous) drops every beat in flight and holds
// busy high until the cycle after reset is released. No state outlives
// an item: the datapath carries no reset, only the valid line does.
module haversine_distance_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [27:0] i_first_latitude,
    input  logic signed [28:0] i_first_longitude,
    input  logic signed [27:0] i_second_latitude,
    input  logic signed [28:0] i_second_longitude,
    output logic               o_done,
    output logic [22:0]        o_distance_km
);

    localparam int L  = hvd_pkg::TOTAL_LAT;
    localparam int AL = hvd_pkg::ASIN_LAT;

    logic               r_busy;
    logic [L-1:0]       r_vld;

    logic signed [27:0] r_lat1, r_lat2, r_clat1, r_clat2;
    logic signed [28:0] r_lon1, r_lon2, r_clon1, r_clon2;

    logic signed [28:0] w_dlat;
    logic signed [29:0] w_dlon;
    logic [28:0]        w_alat1, w_alat2;
    logic [28:0]        r_u [0:3];
    logic [28:0]        w_u [0:3];
    logic [30:0]        w_sin [0:3];

    logic [61:0]        w_p_full, w_q_full, w_sl2_full;
    logic [30:0]        r_p, r_q;
    logic [60:0]        r_sl2, r_sl2d;
    logic [61:0]        w_pq_full;
    logic [60:0]        r_pq;
    logic [61:0]        w_a_full;
    logic [60:0]        r_a, r_b;

    logic [60:0]        w_ny [0:hvd_pkg::SQRT_STEPS];
    logic [61:0]        w_ry [0:hvd_pkg::SQRT_STEPS];
    logic [60:0]        w_nx [0:hvd_pkg::SQRT_STEPS];
    logic [61:0]        w_rx [0:hvd_pkg::SQRT_STEPS];
    logic [30:0]        w_y, w_x;

    logic [30:0]        r_z, r_t0, r_z20;
    logic               r_sel, r_sel_k;
    logic [31:0]        r_sum0;
    logic [61:0]        w_zz;
    logic [AL-1:0]      r_sel_dly;

    logic [30:0]        w_t [0:hvd_pkg::ASIN_TERMS];
    logic [30:0]        w_z2 [0:hvd_pkg::ASIN_TERMS];
    logic [31:0]        w_sum [0:hvd_pkg::ASIN_TERMS];
    logic [31:0]        w_asin;

    logic [31:0]        r_theta;
    logic [53:0]        r_prod;
    logic [53:0]        w_rnd;
    logic [22:0]        r_dist;

    // hold off beats during reset and until the cycle after it is released
    assign busy = r_busy | ~i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_vld  <= '0;
        end else begin
            r_busy <= 1'b0;
            r_vld  <= {r_vld[L-2:0], start & ~busy};
        end
    end

    // capture the beat, then saturate to the coordinate range
    always_ff @(posedge i_clk) begin
        r_lat1 <= i_first_latitude;
        r_lon1 <= i_first_longitude;
        r_lat2 <= i_second_latitude;
        r_lon2 <= i_second_longitude;

        r_clat1 <= (r_lat1 > hvd_pkg::LAT_LIMIT)  ? hvd_pkg::LAT_LIMIT  :
                   (r_lat1 < -hvd_pkg::LAT_LIMIT) ? -hvd_pkg::LAT_LIMIT : r_lat1;
        r_clat2 <= (r_lat2 > hvd_pkg::LAT_LIMIT)  ? hvd_pkg::LAT_LIMIT  :
                   (r_lat2 < -hvd_pkg::LAT_LIMIT) ? -hvd_pkg::LAT_LIMIT : r_lat2;
        r_clon1 <= (r_lon1 > hvd_pkg::LON_LIMIT)  ? hvd_pkg::LON_LIMIT  :
                   (r_lon1 < -hvd_pkg::LON_LIMIT) ? -hvd_pkg::LON_LIMIT : r_lon1;
        r_clon2 <= (r_lon2 > hvd_pkg::LON_LIMIT)  ? hvd_pkg::LON_LIMIT  :
                   (r_lon2 < -hvd_pkg::LON_LIMIT) ? -hvd_pkg::LON_LIMIT : r_lon2;
    end

    // sine arguments in degrees * 2^21: half-angle differences, and the
    // complement of each latitude for the cosines
    always_comb begin
        w_dlat  = 29'(r_clat2) - 29'(r_clat1);
        w_dlon  = 30'(r_clon2) - 30'(r_clon1);
        w_alat1 = r_clat1[27] ? 29'(-r_clat1) : 29'(r_clat1);
        w_alat2 = r_clat2[27] ? 29'(-r_clat2) : 29'(r_clat2);
        w_u[0]  = w_dlat[28] ? 29'(-w_dlat) : 29'(w_dlat);
        w_u[1]  = w_dlon[29] ? 29'(-w_dlon) : 29'(w_dlon);
        w_u[2]  = (29'(hvd_pkg::LAT_LIMIT) - w_alat1) << 1;
        w_u[3]  = (29'(hvd_pkg::LAT_LIMIT) - w_alat2) << 1;
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 4; j++) begin
            r_u[j] <= w_u[j];
        end
    end

    // four sine units side by side: dlat, dlon, cos lat1, cos lat2
    for (genvar g = 0; g < 4; g++) begin : g_sin
        hvd_sin u_sin (
            .i_clk (i_clk),
            .i_u   (r_u[g]),
            .o_sin (w_sin[g])
        );
    end

    // a = sin^2(dlat/2) + sin(dlon/2) cos1 * sin(dlon/2) cos2, clamp to one
    assign w_p_full   = 62'(w_sin[1]) * 62'(w_sin[2]);
    assign w_q_full   = 62'(w_sin[1]) * 62'(w_sin[3]);
    assign w_sl2_full = 62'(w_sin[0]) * 62'(w_sin[0]);
    assign w_pq_full  = 62'(r_p) * 62'(r_q);
    assign w_a_full   = 62'(r_sl2d) + 62'(r_pq);

    always_ff @(posedge i_clk) begin
        r_p    <= w_p_full[60:30];
        r_q    <= w_q_full[60:30];
        r_sl2  <= w_sl2_full[60:0];
        r_pq   <= w_pq_full[60:0];
        r_sl2d <= r_sl2;
        if (w_a_full > 62'(hvd_pkg::ONE_Q60)) begin
            r_a <= hvd_pkg::ONE_Q60;
            r_b <= '0;
        end else begin
            r_a <= w_a_full[60:0];
            r_b <= hvd_pkg::ONE_Q60 - w_a_full[60:0];
        end
    end

    // square roots of a and of one minus a, one root bit per cell
    assign w_ny[0] = r_a;
    assign w_ry[0] = '0;
    assign w_nx[0] = r_b;
    assign w_rx[0] = '0;

    for (genvar s = 0; s < hvd_pkg::SQRT_STEPS; s++) begin : g_sqrt
        hvd_sqrt_cell #(.I(hvd_pkg::SQRT_STEPS - 1 - s)) u_sqrt_y (
            .i_clk (i_clk),
            .i_n   (w_ny[s]),
            .i_res (w_ry[s]),
            .o_n   (w_ny[s+1]),
            .o_res (w_ry[s+1])
        );
        hvd_sqrt_cell #(.I(hvd_pkg::SQRT_STEPS - 1 - s)) u_sqrt_x (
            .i_clk (i_clk),
            .i_n   (w_nx[s]),
            .i_res (w_rx[s]),
            .o_n   (w_nx[s+1]),
            .o_res (w_rx[s+1])
        );
    end

    assign w_y = w_ry[hvd_pkg::SQRT_STEPS][30:0];
    assign w_x = w_rx[hvd_pkg::SQRT_STEPS][30:0];

    // take the arcsine of the smaller root; the larger side uses the
    // complement pi/2 - asin(x)
    assign w_zz = 62'(r_z) * 62'(r_z);

    always_ff @(posedge i_clk) begin
        r_sel   <= (w_y > w_x);
        r_z     <= (w_y > w_x) ? w_x : w_y;
        r_t0    <= r_z;
        r_z20   <= w_zz[60:30];
        r_sum0  <= 32'(r_z);
        r_sel_k <= r_sel;
    end

    assign w_t[0]   = r_t0;
    assign w_z2[0]  = r_z20;
    assign w_sum[0] = r_sum0;

    for (genvar n = 0; n < hvd_pkg::ASIN_TERMS; n++) begin : g_asin
        hvd_asin_cell #(.N(n)) u_asin (
            .i_clk (i_clk),
            .i_t   (w_t[n]),
            .i_z2  (w_z2[n]),
            .i_sum (w_sum[n]),
            .o_t   (w_t[n+1]),
            .o_z2  (w_z2[n+1]),
            .o_sum (w_sum[n+1])
        );
    end

    assign w_asin = w_sum[hvd_pkg::ASIN_TERMS];

    // carry the branch choice alongside the arcsine chain
    always_ff @(posedge i_clk) begin
        r_sel_dly <= {r_sel_dly[AL-2:0], r_sel_k};
    end

    // theta, then 2 * R * theta in km * 256 rounded to nearest, saturated
    assign w_rnd = r_prod + hvd_pkg::DIST_ROUND;

    always_ff @(posedge i_clk) begin
        if (r_sel_dly[AL-1]) begin
            r_theta <= (w_asin > 32'(hvd_pkg::HALF_PI)) ? '0 :
                       32'(hvd_pkg::HALF_PI) - w_asin;
        end else begin
            r_theta <= w_asin;
        end
        r_prod <= 54'(r_theta) * 54'(hvd_pkg::DIST_SCALE);
        if (w_rnd[53:30] > 24'(hvd_pkg::DIST_MAX)) begin
            r_dist <= hvd_pkg::DIST_MAX;
        end else begin
            r_dist <= w_rnd[52:30];
        end
    end

    assign o_done        = r_vld[L-1];
    assign o_distance_km = r_dist;

endmodule

### tb/sv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint LAT_MAX   = 94371840;
    localparam longint LON_MAX   = 188743680;
    localparam longint DEG90_U   = 188743680;
    localparam longint DEG180_U  = 377487360;
    localparam longint PI_Q      = 64'h3243F6A88;
    localparam longint ONE30     = 64'h4000_0000;
    localparam longint ONE60     = 64'h1000_0000_0000_0000;
    localparam longint DMAX      = 5124000;
    localparam longint CYCLE_CAP = 400000;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic signed [27:0] i_first_latitude;
    logic signed [28:0] i_first_longitude;
    logic signed [27:0] i_second_latitude;
    logic signed [28:0] i_second_longitude;
    logic               o_done;
    logic [22:0]        o_distance_km;

    logic [22:0] distance_queue[$];
    int          mismatch_count;
    longint      cycle_count;

    haversine_distance_top i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_first_latitude   (i_first_latitude),
        .i_first_longitude  (i_first_longitude),
        .i_second_latitude  (i_second_latitude),
        .i_second_longitude (i_second_longitude),
        .o_done             (o_done),
        .o_distance_km      (o_distance_km)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Sine of a half angle in degrees * 2^21, Q30 result, truncating series.
    function automatic longint unsigned sine_q30(longint unsigned u);
        longint unsigned r, r2, t;
        longint s;
        if (u > DEG180_U) u = DEG180_U;
        if (u > DEG90_U) u = DEG180_U - u;
        r  = ((u * PI_Q) / 180) >> 23;
        r2 = (r * r) >> 30;
        t  = r;
        s  = longint'(r);
        for (int k = 0; k < 8; k++) begin
            t = ((t * r2) >> 30) / longint'((2 * k + 2) * (2 * k + 3));
            if (k % 2 == 0) s -= longint'(t);
            else s += longint'(t);
        end
        if (s < 0) s = 0;
        if (s > ONE30) s = ONE30;
        return longint'(s);
    endfunction

    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned res, bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned arcsine_q30(longint unsigned z);
        longint unsigned z2, t, sum;
        if (z > ONE30) z = ONE30;
        z2  = (z * z) >> 30;
        t   = z;
        sum = z;
        for (int n = 0; n < 28; n++) begin
            t = (((t * z2) >> 30) * longint'(2 * n + 1)) / longint'(2 * n + 2);
            sum += t / longint'(2 * n + 3);
        end
        return sum;
    endfunction

    function automatic longint saturate(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic longint unsigned mag(longint v);
        return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    function automatic logic [22:0] great_circle_distance(
        logic signed [27:0] lat1_in, logic signed [28:0] lon1_in,
        logic signed [27:0] lat2_in, logic signed [28:0] lon2_in);
        longint lat1, lon1, lat2, lon2;
        longint unsigned slat, slon, c1, c2, p, q, a, y, x, theta, t, span;
        lat1 = saturate(longint'(lat1_in), LAT_MAX);
        lon1 = saturate(longint'(lon1_in), LON_MAX);
        lat2 = saturate(longint'(lat2_in), LAT_MAX);
        lon2 = saturate(longint'(lon2_in), LON_MAX);
        slat = sine_q30(mag(lat2 - lat1));
        slon = sine_q30(mag(lon2 - lon1));
        c1   = sine_q30((LAT_MAX - mag(lat1)) << 1);
        c2   = sine_q30((LAT_MAX - mag(lat2)) << 1);
        p = (slon * c1) >> 30;
        q = (slon * c2) >> 30;
        a = slat * slat + p * q;
        if (a > ONE60) a = ONE60;
        y = root_floor(a);
        x = root_floor(ONE60 - a);
        if (y <= x) begin
            theta = arcsine_q30(y);
        end else begin
            t = arcsine_q30(x);
            theta = (t > (PI_Q >> 3)) ? 0 : (PI_Q >> 3) - t;
        end
        span = (theta * 64'd3261952 + (64'd1 << 29)) >> 30;
        if (span > DMAX) span = DMAX;
        return span[22:0];
    endfunction

    // Present one beat, after an optional random idle gap, and hold it until taken.
    task automatic send_points(logic signed [27:0] lat1, logic signed [28:0] lon1,
                               logic signed [27:0] lat2, logic signed [28:0] lon2);
        int gap;
        gap = $urandom_range(0, 4);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start              <= 1'b1;
        i_first_latitude   <= lat1;
        i_first_longitude  <= lon1;
        i_second_latitude  <= lat2;
        i_second_longitude <= lon2;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        distance_queue = {distance_queue, great_circle_distance(lat1, lon1, lat2, lon2)};
    endtask

    // Drop start once the last beat went in.
    task automatic release_start();
        start <= 1'b0;
    endtask

    task automatic drain_results();
        release_start();
        while (distance_queue.size() != 0) @(posedge i_clk);
    endtask

    // Check every strobed result against the oldest prediction.
    always @(posedge i_clk) begin
        logic [22:0] want;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_done) begin
            if (distance_queue.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: distance %0d", o_distance_km);
            end else begin
                want = distance_queue.pop_front();
                if (want !== o_distance_km) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("distance mismatch: expected %0d, got %0d",
                                 want, o_distance_km);
                end
            end
        end
    end

    // Hard stop if the pipeline never delivers.
    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_CAP) begin
            $display("haversine_distance_top verification failed");
            $finish;
        end
    end

    function automatic logic signed [27:0] rand_lat(bit wide);
        if (wide) return 28'($urandom);
        return 28'(longint'($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX);
    endfunction

    function automatic logic signed [28:0] rand_lon(bit wide);
        if (wide) return 29'($urandom);
        return 29'(longint'($urandom_range(0, 2 * LON_MAX)) - LON_MAX);
    endfunction

    // Corners: poles, antimeridian, identical points, saturation, raw extremes.
    task automatic test_directed();
        logic signed [27:0] lat_max, lat_min, lat_pos, lat_neg;
        logic signed [28:0] lon_max, lon_min, lon_pos, lon_neg;
        lat_max = 28'sh7FF_FFFF;
        lat_min = 28'sh800_0000;
        lat_pos = hvd_pkg::LAT_LIMIT;
        lat_neg = -hvd_pkg::LAT_LIMIT;
        lon_max = 29'shFFF_FFFF;
        lon_min = 29'sh1000_0000;
        lon_pos = hvd_pkg::LON_LIMIT;
        lon_neg = -hvd_pkg::LON_LIMIT;
        send_points(0, 0, 0, 0);
        send_points(lat_pos, 0, lat_neg, 0);
        send_points(lat_pos, lon_pos, lat_pos, lon_neg);
        send_points(0, lon_neg, 0, lon_pos);
        send_points(0, 0, 0, lon_pos);
        send_points(0, 0, 0, lon_neg);
        send_points(lat_max, lon_max, lat_min, lon_min);
        send_points(lat_min, lon_min, lat_max, lon_max);
        send_points(lat_max, 0, lat_pos, 0);
        send_points(0, lon_max, 0, lon_pos);
        send_points(28'sd1, 29'sd1, 28'sd0, 29'sd0);
        send_points(-28'sd1, -29'sd1, 28'sd1, 29'sd1);
        send_points(28'sd47185920, 0, -28'sd47185920, lon_pos);
        send_points(0, 29'sd1000, 0, lon_pos - 29'sd1000);
        send_points(28'sd12345678, 29'sd87654321, 28'sd12345678, 29'sd87654321);
        send_points(lat_neg, lon_min, lat_pos, lon_max);
        send_points(0, 0, 28'sd1, 29'sd0);
        send_points(28'sd5, 0, -28'sd5, 29'sd188743670);
    endtask

    // Random pairs: mostly in range, some across the full field width.
    task automatic test_random(int count);
        bit wide;
        logic signed [27:0] lat1;
        logic signed [28:0] lon1;
        for (int n = 0; n < count; n++) begin
            wide = ($urandom_range(0, 4) == 0);
            lat1 = rand_lat(wide);
            lon1 = rand_lon(wide);
            case ($urandom_range(0, 5))
                0: send_points(lat1, lon1, lat1, lon1);
                1: send_points(lat1, lon1, -lat1, lon1 + 29'sd188743680);
                2: send_points(lat1, lon1, lat1 + 28'($urandom_range(0, 2000)) - 28'sd1000,
                               lon1 + 29'($urandom_range(0, 2000)) - 29'sd1000);
                default: send_points(lat1, lon1, rand_lat(wide), rand_lon(wide));
            endcase
            // Back-to-back stretch: hold start high across beats now and then.
        end
    endtask

    // Pause the sender until every pending result has come back.
    task automatic test_drain_pause();
        drain_results();
        test_random(20);
    endtask

    initial begin
        mismatch_count     = 0;
        cycle_count        = 0;
        i_rst_n            = 1'b0;
        start              = 1'b0;
        i_first_latitude   = '0;
        i_first_longitude  = '0;
        i_second_latitude  = '0;
        i_second_longitude = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(600);
        test_drain_pause();
        test_random(610);
        drain_results();
        repeat (hvd_pkg::TOTAL_LAT + 20) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("haversine_distance_top verification clean");
        else
            $display("haversine_distance_top verification failed");
        $finish;
    end

endmodule

### haversine_distance_top.f
design/hvd_pkg.sv
design/hvd_cdiv.sv
design/hvd_sin_cell.sv
design/hvd_sin.sv
design/hvd_sqrt_cell.sv
design/hvd_asin_cell.sv
design/haversine_distance_top.sv
tb/sv/testbench.sv
